// ----- hw/rtl/stlc_pkg.sv -----
package stlc_pkg;

   // operation codes carried in req_tuser
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_MOVE    = 2'd1,
      OP_STOP    = 2'd2,
      OP_SET_POS = 2'd3
   } op_type;

   // switch event codes
   localparam logic [2:0] SW_EV_NONE      = 3'd0;
   localparam logic [2:0] SW_EV_BOTH      = 3'd1;
   localparam logic [2:0] SW_EV_LIMIT_ONE = 3'd2;
   localparam logic [2:0] SW_EV_LIMIT_TWO = 3'd3;
   localparam logic [2:0] SW_EV_NORMAL    = 3'd4;

   // motion event codes
   localparam logic [1:0] MO_EV_NONE     = 2'd0;
   localparam logic [1:0] MO_EV_DONE     = 2'd1;
   localparam logic [1:0] MO_EV_LIMIT    = 2'd2;
   localparam logic [1:0] MO_EV_SPURIOUS = 2'd3;

   // switch sample patterns
   localparam logic [1:0] SAMPLE_NONE = 2'b00;
   localparam logic [1:0] SAMPLE_ONE  = 2'b01;
   localparam logic [1:0] SAMPLE_TWO  = 2'b10;

   // register indexes (word address)
   localparam logic [1:0] REG_DEFAULT_STEPS   = 2'd0;
   localparam logic [1:0] REG_BACKOFF_STEPS   = 2'd1;
   localparam logic [1:0] REG_PULSES_PER_STEP = 2'd2;

   // register reset values
   localparam logic [15:0] DEFAULT_STEPS_RESET   = 16'd200;
   localparam logic [15:0] BACKOFF_STEPS_RESET   = 16'd200;
   localparam logic [3:0]  PULSES_PER_STEP_RESET = 4'd8;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 112;

endpackage

// ----- hw/rtl/stepper_limit_controller.sv -----
// stepper_limit_controller: focuser stepper control with debounced limit switches
// a result is registered and appears on rsp in the cycle after its request transaction
// throughput: one transaction per cycle; the single result register and the state
//    update in the same cycle set that figure, req_tready follows rsp space
// reset: synchronous, active high; position, limits and steps clear, direction
//    goes outward, registers return to 200 / 200 / 8 and the result register empties
module stepper_limit_controller
   import stlc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata from bit 0: switches[1:0], move_outward, use_default, step_count[30:0],
   // new_position[31:0], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]            req_tuser,
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata from bit 0: step_pulses[3:0], dir_level, position[31:0], switch_event[2:0],
   // motion_event[1:0], limit_one_pos[31:0], limit_two_pos[31:0], is_moving, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [15:0] default_steps_ff;
   logic [15:0] backoff_steps_ff;
   logic [3:0]  pulses_per_step_ff;

   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_steps_ff   <= DEFAULT_STEPS_RESET;
         backoff_steps_ff   <= BACKOFF_STEPS_RESET;
         pulses_per_step_ff <= PULSES_PER_STEP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DEFAULT_STEPS:   default_steps_ff   <= csr_pwdata[15:0];
            REG_BACKOFF_STEPS:   backoff_steps_ff   <= csr_pwdata[15:0];
            REG_PULSES_PER_STEP: pulses_per_step_ff <= csr_pwdata[3:0];
            default: ;  // writes beyond the map are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEFAULT_STEPS:   csr_prdata = {16'd0, default_steps_ff};
         REG_BACKOFF_STEPS:   csr_prdata = {16'd0, backoff_steps_ff};
         REG_PULSES_PER_STEP: csr_prdata = {28'd0, pulses_per_step_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- request fields
   op_type             req_op;
   logic [1:0]         req_switches;
   logic               req_move_outward;
   logic               req_use_default;
   logic [30:0]        req_step_count;
   logic signed [31:0] req_new_position;

   assign req_op           = op_type'(req_tuser);
   assign req_switches     = req_tdata[1:0];
   assign req_move_outward = req_tdata[2];
   assign req_use_default  = req_tdata[3];
   assign req_step_count   = req_tdata[34:4];
   assign req_new_position = req_tdata[66:35];

   // ---------------------------------------------------------------- controller state
   logic signed [31:0] position_ff,  position_in;
   logic [30:0]        steps_left_ff, steps_left_in;
   logic               direction_ff, direction_in;
   logic               moving_ff,    moving_in;
   logic               armed_ff,     armed_in;
   logic [1:0]         prev_ff,      prev_in;
   logic [1:0]         stable_ff,    stable_in;
   logic signed [31:0] limit_one_ff, limit_one_in;
   logic signed [31:0] limit_two_ff, limit_two_in;
   logic [3:0]         pulses;
   logic [2:0]         sw_event;
   logic [1:0]         mo_event;

   logic rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic req_accept;

   // the result register frees up in the same cycle it is drained
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      position_in   = position_ff;
      steps_left_in = steps_left_ff;
      direction_in  = direction_ff;
      moving_in     = moving_ff;
      armed_in      = armed_ff;
      prev_in       = prev_ff;
      stable_in     = stable_ff;
      limit_one_in  = limit_one_ff;
      limit_two_in  = limit_two_ff;
      pulses        = 4'd0;
      sw_event      = SW_EV_NONE;
      mo_event      = MO_EV_NONE;

      unique case (req_op)
         OP_TICK: begin
            // debounce: two equal samples that differ from the stable value,
            // ignored while a limit back-off is armed
            if (!armed_ff && req_switches == prev_ff && req_switches != stable_ff) begin
               case (req_switches)
                  SAMPLE_NONE: sw_event = SW_EV_BOTH;
                  SAMPLE_ONE: begin
                     limit_one_in  = position_ff;
                     direction_in  = ~direction_ff;
                     steps_left_in = 31'(backoff_steps_ff);
                     armed_in      = 1'b1;
                     sw_event      = SW_EV_LIMIT_ONE;
                  end
                  SAMPLE_TWO: begin
                     limit_two_in  = position_ff;
                     direction_in  = ~direction_ff;
                     steps_left_in = 31'(backoff_steps_ff);
                     armed_in      = 1'b1;
                     sw_event      = SW_EV_LIMIT_TWO;
                  end
                  default: sw_event = SW_EV_NORMAL;
               endcase
               stable_in = req_switches;
            end
            prev_in = req_switches;

            // motion uses direction and steps as left by the switch logic
            if (moving_ff) begin
               if (steps_left_in != 31'd0) begin
                  steps_left_in = steps_left_in - 31'd1;
                  position_in   = direction_in ? position_ff + 32'sd1
                                               : position_ff - 32'sd1;
                  pulses        = pulses_per_step_ff;
               end else begin
                  moving_in = 1'b0;
                  mo_event  = armed_in ? MO_EV_LIMIT : MO_EV_DONE;
                  armed_in  = 1'b0;
               end
            end else if (armed_in) begin
               // limit armed after a stop: report it once
               armed_in = 1'b0;
               mo_event = MO_EV_SPURIOUS;
            end
         end
         OP_MOVE: begin
            moving_in     = 1'b1;
            direction_in  = req_move_outward;
            steps_left_in = req_use_default ? 31'(default_steps_ff) : req_step_count;
         end
         OP_STOP: begin
            moving_in = 1'b0;
         end
         OP_SET_POS: begin
            position_in = req_new_position;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         steps_left_ff <= '0;
         direction_ff  <= 1'b1;
         moving_ff     <= 1'b0;
         armed_ff      <= 1'b0;
         prev_ff       <= '0;
         stable_ff     <= '0;
         limit_one_ff  <= '0;
         limit_two_ff  <= '0;
      end else if (req_accept) begin
         position_ff   <= position_in;
         steps_left_ff <= steps_left_in;
         direction_ff  <= direction_in;
         moving_ff     <= moving_in;
         armed_ff      <= armed_in;
         prev_ff       <= prev_in;
         stable_ff     <= stable_in;
         limit_one_ff  <= limit_one_in;
         limit_two_ff  <= limit_two_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= {5'd0, moving_in, limit_two_in, limit_one_in, mo_event,
                          sw_event, position_in, direction_in, pulses};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- checks
   // a motion event always leaves the motor stopped
   a_event_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[41:40] != MO_EV_NONE |-> !rsp_tdata_ff[106])
      else $error("motion event reported while still moving");

   // pulses only come out of a step, and a step keeps the motor moving
   a_pulses_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_tdata_ff[3:0] != 4'd0 |-> rsp_tdata_ff[106])
      else $error("step pulses without motion");

   // commands other than tick report no events and no pulses
   a_cmd_quiet: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser != OP_TICK |=>
         rsp_tdata_ff[41:37] == 5'd0 && rsp_tdata_ff[3:0] == 4'd0)
      else $error("event or pulses on a non-tick command");

   // an armed back-off only comes from a single-switch stable state
   a_armed_stable: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> stable_ff == SAMPLE_ONE || stable_ff == SAMPLE_TWO)
      else $error("limit armed without a single switch closed");

endmodule
